// File: hdl/tg_pkg.sv
// shared constants and coefficient table for the trigamma unit
package tg_pkg;

  parameter int unsigned SHIFT_TERMS_DEF = 6;

  parameter int unsigned ARG_W   = 32;
  parameter int unsigned VALUE_W = 56;
  parameter int unsigned FRAC_IN = 16;

  parameter int unsigned DVS_W   = 33;
  parameter int unsigned Q1_W    = 46;
  parameter int unsigned P_W     = 28;
  parameter int unsigned H_W     = 32;
  parameter int unsigned HS_W    = 35;
  parameter int unsigned S_W     = 31;
  parameter int unsigned SER_W   = 25;
  parameter int unsigned RECIP_W = 57;

  parameter int unsigned HORNER_STEPS = 5;

  parameter logic signed [HS_W-1:0] HORNER_COEF [HORNER_STEPS+1] = '{
    35'sd162688155,
    -35'sd71582788,
    35'sd51130563,
    -35'sd71582788,
    35'sd357913941,
    35'sd2147483648
  };

endpackage

// File: hdl/tg_div.sv
// pipelined restoring divider, one quotient bit per stage
module tg_div #(
  parameter int unsigned NW = 64,
  parameter int unsigned MW = 33,
  parameter int unsigned QW = 46,
  parameter int unsigned SW = 1
) (
  input  logic          clk,
  input  logic          en,
  input  logic [NW-1:0] dividend_i,
  input  logic [MW-1:0] divisor_i,
  input  logic [SW-1:0] side_i,
  output logic [QW-1:0] quot_o,
  output logic [MW-1:0] divisor_o,
  output logic [SW-1:0] side_o
);

  logic [MW-1:0] rem_r  [QW];
  logic [QW-1:0] dq_r   [QW];
  logic [MW-1:0] dvs_r  [QW];
  logic [SW-1:0] side_r [QW];
  logic [MW-1:0] rem0;

  generate
    if (NW == QW) begin : g_nohead
      assign rem0 = '0;
    end else begin : g_head
      assign rem0 = MW'(dividend_i[NW-1:QW]);
    end

    for (genvar s = 0; s < QW; s++) begin : g_stage
      logic [MW-1:0] rem_c;
      logic [QW-1:0] dq_c;
      logic [MW-1:0] dvs_c;
      logic [SW-1:0] side_c;
      logic [MW:0]   t;
      logic [MW:0]   diff;
      logic          ge;

      if (s == 0) begin : g_first
        assign rem_c  = rem0;
        assign dq_c   = dividend_i[QW-1:0];
        assign dvs_c  = divisor_i;
        assign side_c = side_i;
      end else begin : g_next
        assign rem_c  = rem_r[s-1];
        assign dq_c   = dq_r[s-1];
        assign dvs_c  = dvs_r[s-1];
        assign side_c = side_r[s-1];
      end

      assign t    = {rem_c, dq_c[QW-1]};
      assign ge   = t >= {1'b0, dvs_c};
      assign diff = t - {1'b0, dvs_c};

      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[s]  <= ge ? diff[MW-1:0] : t[MW-1:0];
          dq_r[s]   <= {dq_c[QW-2:0], ge};
          dvs_r[s]  <= dvs_c;
          side_r[s] <= side_c;
        end
      end
    end
  endgenerate

  assign quot_o    = dq_r[QW-1];
  assign divisor_o = dvs_r[QW-1];
  assign side_o    = side_r[QW-1];

endmodule

// File: hdl/tg_horner.sv
// horner evaluation of the series polynomial, multiply and add on separate stages
module tg_horner #(
  parameter int unsigned SW = 34
) (
  input  logic                  clk,
  input  logic                  en,
  input  logic [tg_pkg::P_W-1:0] p_i,
  input  logic [SW-1:0]         side_i,
  output logic [tg_pkg::H_W-1:0] h_o,
  output logic [tg_pkg::P_W-1:0] p_o,
  output logic [SW-1:0]         side_o
);

  localparam int unsigned N    = tg_pkg::HORNER_STEPS;
  localparam int unsigned HW   = tg_pkg::HS_W;
  localparam int unsigned PW   = tg_pkg::P_W;
  localparam int unsigned PRW  = (HW - 1) + PW;

  logic [PRW-1:0]       prod_r [N];
  logic                 neg_r  [N];
  logic [PW-1:0]        pm_r   [N];
  logic [SW-1:0]        sm_r   [N];
  logic signed [HW-1:0] h_r    [N];
  logic [PW-1:0]        pa_r   [N];
  logic [SW-1:0]        sa_r   [N];

  generate
    for (genvar j = 0; j < N; j++) begin : g_step
      logic signed [HW-1:0] h_c;
      logic [PW-1:0]        p_c;
      logic [SW-1:0]        s_c;
      logic [HW-2:0]        mag;
      logic [PRW-32:0]      sc;
      logic signed [HW-1:0] val;
      logic signed [HW-1:0] sum;

      if (j == 0) begin : g_first
        assign h_c = tg_pkg::HORNER_COEF[0];
        assign p_c = p_i;
        assign s_c = side_i;
      end else begin : g_next
        assign h_c = h_r[j-1];
        assign p_c = pa_r[j-1];
        assign s_c = sa_r[j-1];
      end

      assign mag = h_c[HW-1] ? (HW-1)'(-h_c) : (HW-1)'(h_c);

      always_ff @(posedge clk) begin
        if (en) begin
          prod_r[j] <= PRW'(mag) * PRW'(p_c);
          neg_r[j]  <= h_c[HW-1];
          pm_r[j]   <= p_c;
          sm_r[j]   <= s_c;
        end
      end

      assign sc  = prod_r[j][PRW-1:31];
      assign val = neg_r[j] ? -$signed(HW'(sc)) : $signed(HW'(sc));
      assign sum = val + tg_pkg::HORNER_COEF[j+1];

      always_ff @(posedge clk) begin
        if (en) begin
          if (j == N - 1 && sum < 0) begin
            h_r[j] <= '0;
          end else begin
            h_r[j] <= sum;
          end
          pa_r[j] <= pm_r[j];
          sa_r[j] <= sm_r[j];
        end
      end
    end
  endgenerate

  assign h_o    = h_r[N-1][tg_pkg::H_W-1:0];
  assign p_o    = pa_r[N-1];
  assign side_o = sa_r[N-1];

endmodule

// File: hdl/tg_tree.sv
// registered adder tree over the recurrence terms
module tg_tree #(
  parameter int unsigned N = 6,
  parameter int unsigned W = 57,
  localparam int unsigned L  = $clog2(N),
  localparam int unsigned OW = W + L
) (
  input  logic                clk,
  input  logic                en,
  input  logic [N-1:0][W-1:0] leaf_i,
  output logic [OW-1:0]       sum_o
);

  localparam int unsigned LEAVES = 1 << L;

  logic [OW-1:0] pad  [LEAVES];
  logic [OW-1:0] node_r [L][LEAVES/2];

  generate
    for (genvar i = 0; i < LEAVES; i++) begin : g_pad
      if (i < N) begin : g_used
        assign pad[i] = OW'(leaf_i[i]);
      end else begin : g_zero
        assign pad[i] = '0;
      end
    end

    for (genvar lev = 0; lev < L; lev++) begin : g_lev
      for (genvar i = 0; i < (LEAVES >> (lev + 1)); i++) begin : g_node
        if (lev == 0) begin : g_base
          always_ff @(posedge clk) begin
            if (en) begin
              node_r[lev][i] <= pad[2*i] + pad[2*i+1];
            end
          end
        end else begin : g_up
          always_ff @(posedge clk) begin
            if (en) begin
              node_r[lev][i] <= node_r[lev-1][2*i] + node_r[lev-1][2*i+1];
            end
          end
        end
      end
    end
  endgenerate

  assign sum_o = node_r[L-1][0];

endmodule

// File: hdl/tg_delay.sv
// enabled delay line for aligning the series path
module tg_delay #(
  parameter int unsigned W     = 26,
  parameter int unsigned DEPTH = 1
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] d_i,
  output logic [W-1:0] q_o
);

  generate
    if (DEPTH == 0) begin : g_none
      assign q_o = d_i;
    end else begin : g_line
      logic [W-1:0] tap_r [DEPTH];
      for (genvar i = 0; i < DEPTH; i++) begin : g_tap
        always_ff @(posedge clk) begin
          if (en) begin
            tap_r[i] <= (i == 0) ? d_i : tap_r[(i == 0) ? 0 : i-1];
          end
        end
      end
      assign q_o = tap_r[DEPTH-1];
    end
  endgenerate

endmodule

// File: hdl/trigamma_function_unit.sv
// trigamma unit top level: pipeline control, series path, recurrence lanes and final sum
// Takes one Q16.16 argument per cycle and returns trigamma in Q32.24, one
// result per cycle, when out_stall stays low. The pipe is built from the
// bit-per-stage dividers: 2^63/D, then /D, the Horner stages and the final /D
// on the series side, and two 57-stage divisions in each recurrence lane
// followed by the adder tree. The whole pipe holds while out_stall is high and
// a result waits; a zero argument returns all ones with out_zero_input set.
module trigamma_function_unit #(
  parameter int unsigned SHIFT_TERMS = tg_pkg::SHIFT_TERMS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [tg_pkg::ARG_W-1:0]      in_arg,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [tg_pkg::VALUE_W-1:0]    out_value,
  output logic                          out_zero_input
);

  localparam int unsigned L     = $clog2(SHIFT_TERMS);
  localparam int unsigned DW    = tg_pkg::DVS_W;
  localparam int unsigned RW    = tg_pkg::RECIP_W;
  localparam int unsigned TW    = RW + L;
  localparam int unsigned LAT   = 116 + L;
  localparam int unsigned ALIGN = L - 2;

  logic           adv;
  logic [LAT-1:0] vld_r;

  logic [tg_pkg::ARG_W-1:0] a_r;
  logic [DW-1:0]            d0_r;
  logic                     z0_r;

  assign adv      = !vld_r[LAT-1] || !out_stall;
  assign in_stall = !adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[LAT-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_r  <= in_arg;
      d0_r <= DW'(in_arg) + (DW'(SHIFT_TERMS) << tg_pkg::FRAC_IN);
      z0_r <= (in_arg == '0);
    end
  end

  // series path
  logic [tg_pkg::Q1_W-1:0] q1;
  logic [DW-1:0]           d1;
  logic                    z1;
  logic [tg_pkg::P_W-1:0]  p2;
  logic [DW-1:0]           d2;
  logic                    z2;
  logic [tg_pkg::H_W-1:0]  h3;
  logic [tg_pkg::P_W-1:0]  p3;
  logic [DW:0]             sd3;
  logic [tg_pkg::S_W-1:0]  s4;
  logic [tg_pkg::P_W:0]    pz4;
  logic [tg_pkg::SER_W-1:0] ser_r;
  logic                    zs_r;
  logic [tg_pkg::SER_W:0]  ser_dly;
  logic [tg_pkg::S_W:0]    ser_sum;

  tg_div #(.NW(64), .MW(DW), .QW(tg_pkg::Q1_W), .SW(1)) u_div_recip (
    .clk(clk), .en(adv),
    .dividend_i(64'h8000_0000_0000_0000), .divisor_i(d0_r), .side_i(z0_r),
    .quot_o(q1), .divisor_o(d1), .side_o(z1)
  );

  tg_div #(.NW(tg_pkg::Q1_W), .MW(DW), .QW(tg_pkg::P_W), .SW(1)) u_div_sq (
    .clk(clk), .en(adv),
    .dividend_i(q1), .divisor_i(d1), .side_i(z1),
    .quot_o(p2), .divisor_o(d2), .side_o(z2)
  );

  tg_horner #(.SW(DW + 1)) u_horner (
    .clk(clk), .en(adv),
    .p_i(p2), .side_i({d2, z2}),
    .h_o(h3), .p_o(p3), .side_o(sd3)
  );

  tg_div #(.NW(tg_pkg::H_W + 16), .MW(DW), .QW(tg_pkg::S_W), .SW(tg_pkg::P_W + 1)) u_div_ser (
    .clk(clk), .en(adv),
    .dividend_i({h3, 16'h0000}), .divisor_i(sd3[DW:1]), .side_i({p3, sd3[0]}),
    .quot_o(s4), .divisor_o(), .side_o(pz4)
  );

  assign ser_sum = (tg_pkg::S_W + 1)'(s4) + (tg_pkg::S_W + 1)'(pz4[tg_pkg::P_W:2]);

  always_ff @(posedge clk) begin
    if (adv) begin
      ser_r <= ser_sum[tg_pkg::S_W:7];
      zs_r  <= pz4[0];
    end
  end

  tg_delay #(.W(tg_pkg::SER_W + 1), .DEPTH(ALIGN)) u_align (
    .clk(clk), .en(adv), .d_i({ser_r, zs_r}), .q_o(ser_dly)
  );

  // recurrence lanes
  logic [SHIFT_TERMS-1:0][RW-1:0] term;
  logic [TW-1:0]                  rec_sum;

  generate
    for (genvar k = 0; k < SHIFT_TERMS; k++) begin : g_lane
      logic [DW-1:0] dk;
      logic [RW-1:0] r1;
      logic [DW-1:0] dk1;

      assign dk = DW'(a_r) + (DW'(k) << tg_pkg::FRAC_IN);

      tg_div #(.NW(RW), .MW(DW), .QW(RW), .SW(1)) u_div_a (
        .clk(clk), .en(adv),
        .dividend_i(RW'(1) << 56), .divisor_i(dk), .side_i(1'b0),
        .quot_o(r1), .divisor_o(dk1), .side_o()
      );

      tg_div #(.NW(RW), .MW(DW), .QW(RW), .SW(1)) u_div_b (
        .clk(clk), .en(adv),
        .dividend_i(r1), .divisor_i(dk1), .side_i(1'b0),
        .quot_o(term[k]), .divisor_o(), .side_o()
      );
    end
  endgenerate

  tg_tree #(.N(SHIFT_TERMS), .W(RW)) u_tree (
    .clk(clk), .en(adv), .leaf_i(term), .sum_o(rec_sum)
  );

  // final sum and saturation
  logic [TW:0] total;

  assign total = (TW + 1)'(ser_dly[tg_pkg::SER_W:1]) + (TW + 1)'(rec_sum);

  always_ff @(posedge clk) begin
    if (adv) begin
      out_zero_input <= ser_dly[0];
      if (ser_dly[0] || (total[TW:tg_pkg::VALUE_W] != '0)) begin
        out_value <= '1;
      end else begin
        out_value <= total[tg_pkg::VALUE_W-1:0];
      end
    end
  end

  assign out_valid = vld_r[LAT-1];

  a_zero_saturates: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_zero_input |-> (&out_value))
    else $error("zero request without saturated value");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input held while output free");

  a_reset_empties: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result present after reset");

endmodule
